>>> rtl/core/bslp_pkg.sv
// Package for the button short/long press detector.
// Holds the shared item type, configuration type, codes and the saturating increment.
// Used by every module of the block; depends on nothing else.
package bslp_pkg;

  localparam int unsigned CntW = 16;

  localparam logic [CntW-1:0] CNT_MAX    = 16'hFFFF;
  localparam logic [CntW-1:0] DEB_RESET  = 16'd50;
  localparam logic [CntW-1:0] LONG_RESET = 16'd2000;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd1;

  // Request codes.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Pin levels (active low button).
  localparam logic PIN_PRESSED = 1'b0;

  // Event codes.
  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_SHORT = 2'd1;
  localparam logic [1:0] EVT_LONG  = 2'd2;

  // One input transaction.
  typedef struct packed {
    logic       req_type;
    logic       pin_level;
    logic [1:0] new_state;
  } item_t;

  // Configuration registers.
  typedef struct packed {
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] long_press_ticks;
  } cfg_t;

  // Counter increment that stops at the top value.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    return r;
  endfunction

endpackage

>>> rtl/core/bslp_in_reg.sv
// Input register stage of the button press detector.
// Captures one input transaction and holds it until the core takes it.
// Depends on bslp_pkg.
module bslp_in_reg
  import bslp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Stall only while a held transaction cannot move on this cycle.
  assign in_stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/core/bslp_core.sv
// Press detection core: debounce, hold and release counters, sticky event state
// and the result register. Updates state once per transaction taken from the
// input stage. Depends on bslp_pkg.
module bslp_core
  import bslp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       take_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_state_o
);

  logic [CntW-1:0] press_q, press_d;
  logic [CntW-1:0] rel_q, rel_d;
  logic [CntW-1:0] hold_q, hold_d;
  logic            short_q, short_d;
  logic            long_q, long_d;
  logic [1:0]      evt_q, evt_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_evt_q;
  logic [CntW-1:0] press_inc;
  logic            advance;

  // The result register is free when empty or being drained.
  assign take_o  = !out_valid_q || !out_stall_i;
  assign advance = valid_i && take_o;
  assign press_inc = sat_inc(press_q);

  // Next state for one transaction.
  always_comb begin
    press_d = press_q;
    rel_d   = rel_q;
    hold_d  = hold_q;
    short_d = short_q;
    long_d  = long_q;
    evt_d   = evt_q;
    if (advance) begin
      if (item_i.req_type == REQ_WRITE) begin
        evt_d   = item_i.new_state;
        press_d = '0;
      end else if (item_i.pin_level == PIN_PRESSED) begin
        press_d = press_inc;
        if (press_inc > cfg_i.debounce_ticks && !long_q) begin
          if (hold_q > cfg_i.long_press_ticks) begin
            long_d  = 1'b1;
            evt_d   = EVT_LONG;
            press_d = '0;
            hold_d  = '0;
            short_d = 1'b0;
          end else begin
            short_d = 1'b1;
            hold_d  = sat_inc(hold_q);
          end
        end
        rel_d = '0;
      end else begin
        // Released: raise a short press once the release is debounced.
        if (short_q && rel_q > cfg_i.debounce_ticks) begin
          if (hold_q < cfg_i.long_press_ticks) begin
            evt_d = EVT_SHORT;
          end
          short_d = 1'b0;
        end
        long_d  = 1'b0;
        rel_d   = sat_inc(rel_q);
        hold_d  = '0;
        press_d = '0;
      end
    end
  end

  // Result valid follows the input stage whenever the result register moves.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= '0;
      rel_q       <= '0;
      hold_q      <= '0;
      short_q     <= 1'b0;
      long_q      <= 1'b0;
      evt_q       <= EVT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      press_q     <= press_d;
      rel_q       <= rel_d;
      hold_q      <= hold_d;
      short_q     <= short_d;
      long_q      <= long_d;
      evt_q       <= evt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload carries the event state after the transaction.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_evt_q <= evt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_state_o = out_evt_q;

`ifndef SYNTH
  // A pending short press and a reported long press exclude each other.
  a_short_long_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(short_q && long_q))
    else $error("short pending and long reported both set");

  // Counting release time implies the hold counter was cleared.
  a_rel_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rel_q != '0) |-> (hold_q == '0))
    else $error("hold counter nonzero while release counter runs");

  // A long press report always latches the long event.
  a_long_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(long_q) |-> (evt_q == EVT_LONG))
    else $error("long press reported without long event");

  // State changes only when a transaction is taken.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(evt_q) && $stable(hold_q) && $stable(rel_q))
    else $error("state changed without a transaction");
`endif

endmodule

>>> rtl/core/button_short_long_press.sv
// Top level of the button short/long press detector.
// Holds the configuration registers and connects input stage and core.
// Depends on bslp_pkg, bslp_in_reg and bslp_core.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per
//   millisecond tick: req_type_i = 0 brings the raw active-low pin sample,
//   req_type_i = 1 writes the sticky event state from new_state_i (used by
//   software to acknowledge an event).
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   input transaction: the event state after that transaction.
//   The input register takes the transaction, and the counter update then
//   loads the result register. Throughput is one transaction per cycle while
//   out_stall_i is low, set by the single counter update between the two
//   registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_stall_o rises; no transaction is lost or repeated.
//   Reset clears all counters and the event state and loads the thresholds
//   with 50 (debounce) and 2000 (long press). Configuration writes take
//   effect at the next clock edge and belong to idle periods.
module button_short_long_press
  import bslp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic               pin_level_i,
  input  logic [1:0]         new_state_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         event_state_o
);

  cfg_t  cfg_q, cfg_d;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  take;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:   cfg_d.debounce_ticks   = cfg_wdata_i;
        REG_LONG_PRESS: cfg_d.long_press_ticks = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DEB_RESET;
      cfg_q.long_press_ticks <= LONG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.req_type  = req_type_i;
  assign in_item.pin_level = pin_level_i;
  assign in_item.new_state = new_state_i;

  bslp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  bslp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (s1_valid),
    .item_i        (s1_item),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_state_o (event_state_o)
  );

endmodule
